@@ rtl/tzb_pkg.sv @@
// Package for the triangle z-buffer pixel test block.
// Holds the channel payload types, queue entry type and fixed widths.
// No dependencies.
package tzb_pkg;

  localparam int CoordW = 10;
  localparam int DepthW = 16;
  localparam int WeightW = 24;
  localparam int AccW = 42;
  localparam int QuotW = 17;
  localparam int AddrW = 2 * CoordW;
  localparam int StoreDepth = 1 << AddrW;
  localparam logic signed [DepthW-1:0] DepthMin = 16'sh8000;

  localparam logic ModeTest = 1'b0;
  localparam logic ModeClear = 1'b1;

  typedef struct packed {
    logic mode;
    logic [CoordW-1:0] ax;
    logic [CoordW-1:0] ay;
    logic signed [DepthW-1:0] az;
    logic [CoordW-1:0] bx;
    logic [CoordW-1:0] by_row;
    logic signed [DepthW-1:0] bz;
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic signed [DepthW-1:0] cz;
    logic [CoordW-1:0] px;
    logic [CoordW-1:0] py;
  } tzb_in_t;

  typedef struct packed {
    logic [CoordW-1:0] pixel_col;
    logic [CoordW-1:0] pixel_row;
    logic inside_res;
    logic write_pixel;
    logic signed [DepthW-1:0] depth;
  } tzb_out_t;

  // One classified item handed from the front end to the back end.
  typedef struct packed {
    logic mode;
    logic covered;
    logic vis;
    logic [CoordW-1:0] px;
    logic [CoordW-1:0] py;
    logic signed [DepthW-1:0] az;
    logic signed [DepthW-1:0] bz;
    logic signed [DepthW-1:0] cz;
    logic signed [WeightW-1:0] wa;
    logic signed [WeightW-1:0] wb;
    logic signed [WeightW-1:0] wc;
    logic signed [WeightW-1:0] uz;
  } tzb_entry_t;

endpackage

@@ rtl/triangle_zbuffer_pixel_test_top.sv @@
// Usage notes:
// Input channel in_valid/in_stall/in_data carries one item: mode, three
// vertices with Q1.14 depths, and a pixel. Output channel
// out_valid/out_stall/out_data returns one result per item, in order.
// An item is taken at an edge with valid high and stall low.
// A covered test item's result passes the back end's multiply, divide-setup,
// divide, read and output steps; an uncovered or clear item's goes from idle
// to the read and output steps. The back end handles one item at a time and
// takes no new item from the queue until it has loaded the last result; the
// depth sum over three vertices and the bit-serial divider slow covered pixels.
// A two-stage front end and a two-entry queue take items while the back end
// works. The output register holds a result while out_stall is high and
// the back end waits in its final step until it frees.
// Reset: rst starts a clearing pass over the whole 2^20-entry depth store,
// one entry a cycle, with in_stall held high until it ends.
// Depends on tzb_pkg, tzb_front, tzb_fifo and tzb_back.
module triangle_zbuffer_pixel_test_top #(
  parameter int SCREEN_W = 1024,
  parameter int SCREEN_H = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  tzb_pkg::tzb_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tzb_pkg::tzb_out_t out_data
);
  import tzb_pkg::*;

  logic advance, take, push, q_full, q_not_empty, pop, clearing;
  tzb_entry_t push_data, q_data;

  assign in_stall = clearing || !advance;
  assign take = in_valid && !in_stall;

  // Front end: differences, products and classification.
  tzb_front #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_front (
    .clk(clk), .rst(rst), .take(take), .item(in_data), .advance(advance),
    .q_full(q_full), .push(push), .push_data(push_data)
  );

  // Queue decoupling the two halves.
  tzb_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .full(q_full),
    .pop(pop), .not_empty(q_not_empty), .pop_data(q_data)
  );

  // Back end: interpolation, division and depth store.
  tzb_back u_back (
    .clk(clk), .rst(rst), .clearing(clearing), .q_not_empty(q_not_empty),
    .q_data(q_data), .pop(pop), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

endmodule

@@ rtl/tzb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tzb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/tzb_fifo.sv @@
// Two-entry queue between the front end and the back end.
// Depends on tzb_pkg for the entry type.
module tzb_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tzb_pkg::tzb_entry_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output tzb_pkg::tzb_entry_t pop_data
);
  import tzb_pkg::*;

  tzb_entry_t slots [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  assign full = count[1];
  assign not_empty = (count != 2'd0);
  assign pop_data = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push || pop)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
`endif

endmodule

@@ rtl/tzb_front.sv @@
// Front end: takes items, forms edge cross products and classifies coverage.
// Depends on tzb_pkg; feeds tzb_fifo.
module tzb_front #(
  parameter int SCREEN_W = 1024,
  parameter int SCREEN_H = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  tzb_pkg::tzb_in_t    item,
  output logic                advance,
  input  logic                q_full,
  output logic                push,
  output tzb_pkg::tzb_entry_t push_data
);
  import tzb_pkg::*;

  localparam int DiffW = CoordW + 1;
  localparam int ProdW = 2 * DiffW;

  // Stage A: coordinate differences.
  logic a_valid;
  logic a_mode;
  logic [CoordW-1:0] a_px, a_py;
  logic signed [DepthW-1:0] a_az, a_bz, a_cz;
  logic signed [DiffW-1:0] e1x, e1y, e2x, e2y, dx, dy;

  // Stage B: products.
  logic b_valid;
  logic b_mode;
  logic [CoordW-1:0] b_px, b_py;
  logic signed [DepthW-1:0] b_az, b_bz, b_cz;
  logic signed [ProdW-1:0] p_e1x_dy, p_dx_e1y, p_dx_e2y, p_e2x_dy, p_e2x_e1y, p_e1x_e2y;

  logic signed [WeightW-1:0] wa, wb, wc, uz;
  logic side_a, side_b, side_c;

  assign advance = !(b_valid && q_full);
  assign push = b_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= take;
      b_valid <= a_valid;
    end
  end

  // Differences relative to the first vertex.
  always_ff @(posedge clk) begin
    if (advance) begin
      a_mode <= item.mode;
      a_px <= item.px;
      a_py <= item.py;
      a_az <= item.az;
      a_bz <= item.bz;
      a_cz <= item.cz;
      e1x <= $signed({1'b0, item.bx}) - $signed({1'b0, item.ax});
      e1y <= $signed({1'b0, item.by_row}) - $signed({1'b0, item.ay});
      e2x <= $signed({1'b0, item.cx}) - $signed({1'b0, item.ax});
      e2y <= $signed({1'b0, item.cy}) - $signed({1'b0, item.ay});
      dx <= $signed({1'b0, item.ax}) - $signed({1'b0, item.px});
      dy <= $signed({1'b0, item.ay}) - $signed({1'b0, item.py});
    end
  end

  // Six independent small products.
  always_ff @(posedge clk) begin
    if (advance) begin
      b_mode <= a_mode;
      b_px <= a_px;
      b_py <= a_py;
      b_az <= a_az;
      b_bz <= a_bz;
      b_cz <= a_cz;
      p_e1x_dy <= e1x * dy;
      p_dx_e1y <= dx * e1y;
      p_dx_e2y <= dx * e2y;
      p_e2x_dy <= e2x * dy;
      p_e2x_e1y <= e2x * e1y;
      p_e1x_e2y <= e1x * e2y;
    end
  end

  // Weights and coverage classification.
  always_comb begin
    wc = WeightW'(p_e1x_dy) - WeightW'(p_dx_e1y);
    wb = WeightW'(p_dx_e2y) - WeightW'(p_e2x_dy);
    uz = WeightW'(p_e2x_e1y) - WeightW'(p_e1x_e2y);
    wa = uz - wb - wc;
    side_a = uz[WeightW-1] ? (wa <= 0) : !wa[WeightW-1];
    side_b = uz[WeightW-1] ? (wb <= 0) : !wb[WeightW-1];
    side_c = uz[WeightW-1] ? (wc <= 0) : !wc[WeightW-1];
    push_data.mode = b_mode;
    push_data.covered = (b_mode == ModeTest) && (uz != '0) && side_a && side_b && side_c;
    push_data.vis = ({3'b000, b_px} < 13'(SCREEN_W)) && ({3'b000, b_py} < 13'(SCREEN_H));
    push_data.px = b_px;
    push_data.py = b_py;
    push_data.az = b_az;
    push_data.bz = b_bz;
    push_data.cz = b_cz;
    push_data.wa = wa;
    push_data.wb = wb;
    push_data.wc = wc;
    push_data.uz = uz;
  end

endmodule

@@ rtl/tzb_back.sv @@
// Back end: depth interpolation, iterative division and depth store update.
// Depends on tzb_pkg and tzb_ram; fed by tzb_fifo.
module tzb_back (
  input  logic                clk,
  input  logic                rst,
  output logic                clearing,
  input  logic                q_not_empty,
  input  tzb_pkg::tzb_entry_t q_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output tzb_pkg::tzb_out_t   out_data
);
  import tzb_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_DVS  = 6'b000100,
    S_DIV  = 6'b001000,
    S_RD   = 6'b010000,
    S_OUT  = 6'b100000
  } back_state_t;

  localparam int RemW = WeightW + 1;

  back_state_t state;
  tzb_entry_t ent;
  logic signed [AccW-1:0] acc;
  logic [1:0] mcnt;
  logic [RemW-1:0] rem;
  logic [QuotW-1:0] qsh;
  logic [RemW-1:0] den;
  logic neg;
  logic [4:0] dcnt;
  logic signed [DepthW-1:0] depth_r;
  logic [AddrW-1:0] clr_addr;

  logic signed [WeightW-1:0] mul_w;
  logic signed [DepthW-1:0] mul_z;
  logic signed [AccW-1:0] nabs;
  logic [RemW-1:0] trial;
  logic [QuotW-1:0] qneg;
  logic out_free;
  logic ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, pix_addr;
  logic [DepthW-1:0] ram_wdata, ram_rdata;
  logic pass;

  assign pop = (state == S_IDLE) && !clearing && q_not_empty;
  assign out_free = !out_valid || !out_stall;
  assign pix_addr = {ent.py, ent.px};

  always_comb begin
    unique case (mcnt)
      2'd0: begin mul_w = ent.wa; mul_z = ent.az; end
      2'd1: begin mul_w = ent.wb; mul_z = ent.bz; end
      default: begin mul_w = ent.wc; mul_z = ent.cz; end
    endcase
    nabs = acc[AccW-1] ? -acc : acc;
    trial = {rem[RemW-2:0], qsh[QuotW-1]};
    qneg = neg ? -qsh : qsh;
    pass = ent.vis && ent.covered && ($signed(depth_r) > $signed(ram_rdata));
  end

  // Store write port: clearing pass first, then item writes.
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = pix_addr;
    ram_wdata = depth_r;
    if (clearing) begin
      ram_we = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = DepthMin;
    end else if (state == S_OUT && out_free) begin
      if (ent.mode == ModeClear) begin
        ram_we = ent.vis;
        ram_wdata = DepthMin;
      end else begin
        ram_we = pass;
      end
    end
  end

  assign ram_re = (state == S_RD);

  tzb_ram #(.WIDTH(DepthW), .DEPTH(StoreDepth)) u_store (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(pix_addr), .rdata(ram_rdata)
  );

  // Clearing pass after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // A result is held while stalled and a new one is loaded from the final step.
      out_valid <= (state == S_OUT && out_free) || (out_valid && out_stall);
      unique case (state)
        S_IDLE: if (pop) begin
          state <= (q_data.mode == ModeTest && q_data.covered) ? S_MUL : S_RD;
        end
        S_MUL: if (mcnt == 2'd2) begin
          state <= S_DVS;
        end
        S_DVS: state <= S_DIV;
        S_DIV: if (dcnt == 5'(QuotW - 1)) begin
          state <= S_RD;
        end
        S_RD: state <= S_OUT;
        S_OUT: if (out_free) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        ent <= q_data;
        acc <= '0;
        mcnt <= 2'd0;
      end
      S_MUL: begin
        acc <= acc + AccW'(mul_w * mul_z);
        mcnt <= mcnt + 2'd1;
      end
      S_DVS: begin
        rem <= RemW'(nabs[AccW-1:QuotW]);
        qsh <= nabs[QuotW-1:0];
        den <= RemW'(ent.uz[WeightW-1] ? -ent.uz : ent.uz);
        neg <= acc[AccW-1] ^ ent.uz[WeightW-1];
        dcnt <= '0;
      end
      S_DIV: begin
        if (trial >= den) begin
          rem <= trial - den;
          qsh <= {qsh[QuotW-2:0], 1'b1};
        end else begin
          rem <= trial;
          qsh <= {qsh[QuotW-2:0], 1'b0};
        end
        dcnt <= dcnt + 5'd1;
      end
      S_RD: begin
        depth_r <= (ent.mode == ModeTest && ent.covered) ? qneg[DepthW-1:0] : '0;
      end
      S_OUT: begin
        if (out_free) begin
          out_data.pixel_col <= ent.px;
          out_data.pixel_row <= ent.py;
          out_data.inside_res <= (ent.mode == ModeTest) && ent.covered;
          out_data.write_pixel <= (ent.mode == ModeTest) && pass;
          out_data.depth <= depth_r;
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !pop)
    else $error("item taken during clearing pass");
  a_write_needs_inside: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !out_data.write_pixel || out_data.inside_res)
    else $error("pixel write flagged for an uncovered pixel");
  a_outside_zero_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.inside_res |-> out_data.depth == '0)
    else $error("nonzero depth for an uncovered pixel");
  a_div_from_mul: assert property (@(posedge clk) disable iff (rst)
    state == S_DVS |-> $past(state) == S_MUL)
    else $error("division started without a depth sum");
`endif

endmodule

@@ tb/triangle_zbuffer_pixel_test_top_tb.sv @@
// Testbench for the triangle z-buffer pixel test block.
// Predicts coverage, interpolated depth and store updates per item and checks results.
// Depends on tzb_pkg and triangle_zbuffer_pixel_test_top.
module triangle_zbuffer_pixel_test_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tzb_pkg::*;

  localparam int ScreenW = 1024;
  localparam int ScreenH = 1024;
  localparam longint CycleLimit = 64'd6000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  tzb_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tzb_out_t out_data;

  // Idle and stall rates, in percent.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  longint cycles = 0;

  // Model of the depth store; entries not present are still at the minimum.
  logic signed [DepthW-1:0] zbuf_model [int];
  tzb_out_t pending_pixels[$];

  triangle_zbuffer_pixel_test_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Cycle counter with a timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("triangle_zbuffer_pixel_test_top verification failed");
      $finish;
    end
  end

  // Random receiver stall.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic signed [DepthW-1:0] stored_depth(int idx);
    if (zbuf_model.exists(idx)) return zbuf_model[idx];
    return DepthMin;
  endfunction

  // Works out the result of one item and updates the store model.
  function automatic tzb_out_t shade_pixel(tzb_in_t t);
    tzb_out_t r;
    longint e1x, e1y, e2x, e2y, dx, dy, wa, wb, wc, uz, num, z;
    bit vis, cov;
    int idx;
    r = '0;
    r.pixel_col = t.px;
    r.pixel_row = t.py;
    vis = (t.px < ScreenW) && (t.py < ScreenH);
    idx = int'(t.py) * ScreenW + int'(t.px);
    if (t.mode == ModeClear) begin
      if (vis) zbuf_model.delete(idx);
      return r;
    end
    e1x = longint'(t.bx) - longint'(t.ax);
    e1y = longint'(t.by_row) - longint'(t.ay);
    e2x = longint'(t.cx) - longint'(t.ax);
    e2y = longint'(t.cy) - longint'(t.ay);
    dx = longint'(t.ax) - longint'(t.px);
    dy = longint'(t.ay) - longint'(t.py);
    wc = e1x * dy - dx * e1y;
    wb = dx * e2y - e2x * dy;
    uz = e2x * e1y - e1x * e2y;
    wa = uz - wb - wc;
    if (uz > 0) cov = (wa >= 0) && (wb >= 0) && (wc >= 0);
    else cov = (uz != 0) && (wa <= 0) && (wb <= 0) && (wc <= 0);
    if (!cov) return r;
    num = wa * longint'(t.az) + wb * longint'(t.bz) + wc * longint'(t.cz);
    z = num / uz;
    if (z > 32767) z = 32767;
    if (z < -32768) z = -32768;
    r.inside_res = 1'b1;
    r.depth = z[DepthW-1:0];
    if (vis && z > longint'(stored_depth(idx))) begin
      zbuf_model[idx] = z[DepthW-1:0];
      r.write_pixel = 1'b1;
    end
    return r;
  endfunction

  // Checks each accepted result against the oldest expectation.
  always @(posedge clk) begin
    tzb_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_data.pixel_col !== want.pixel_col)
          $display("%0t: pixel_col expected %0d actual %0d", $time, want.pixel_col,
                   out_data.pixel_col);
        if (out_data.pixel_row !== want.pixel_row)
          $display("%0t: pixel_row expected %0d actual %0d", $time, want.pixel_row,
                   out_data.pixel_row);
        if (out_data.inside_res !== want.inside_res)
          $display("%0t: inside_res expected %0d actual %0d", $time, want.inside_res,
                   out_data.inside_res);
        if (out_data.write_pixel !== want.write_pixel)
          $display("%0t: write_pixel expected %0d actual %0d", $time, want.write_pixel,
                   out_data.write_pixel);
        if (out_data.depth !== want.depth)
          $display("%0t: depth expected %0d actual %0d", $time, want.depth,
                   out_data.depth);
        if (out_data !== want) errors++;
      end
    end
  end

  // Sends one item; valid stays high across back-to-back items.
  task automatic send_item(tzb_in_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_pixels.push_back(shade_pixel(t));
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    go_idle();
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  function automatic tzb_in_t make_tri(int ax, int ay, int bx, int by, int cx, int cy,
                                      int az, int bz, int cz, int px, int py);
    tzb_in_t t;
    t = '0;
    t.mode = ModeTest;
    t.ax = CoordW'(ax); t.ay = CoordW'(ay);
    t.bx = CoordW'(bx); t.by_row = CoordW'(by);
    t.cx = CoordW'(cx); t.cy = CoordW'(cy);
    t.az = DepthW'(az); t.bz = DepthW'(bz); t.cz = DepthW'(cz);
    t.px = CoordW'(px); t.py = CoordW'(py);
    return t;
  endfunction

  function automatic tzb_in_t make_clear(int px, int py);
    tzb_in_t t;
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    t = tzb_in_t'(raw[$bits(tzb_in_t)-1:0]);
    t.mode = ModeClear;
    t.px = CoordW'(px);
    t.py = CoordW'(py);
    return t;
  endfunction

  // Random item; mostly small triangles around a pixel so coverage is common.
  function automatic tzb_in_t random_item();
    tzb_in_t t;
    logic [159:0] raw;
    int bx, by, span, sel;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    t = tzb_in_t'(raw[$bits(tzb_in_t)-1:0]);
    sel = $urandom_range(99);
    if (sel < 10) begin
      t.mode = ModeClear;
    end else if (sel < 80) begin
      // Localized triangle, usually on a small pixel patch, so the store gets reused.
      t.mode = ModeTest;
      span = ($urandom_range(9) == 0) ? 1023 : 40;
      bx = $urandom_range(1023 - span);
      by = $urandom_range(1023 - span);
      t.ax = CoordW'(bx + $urandom_range(span));
      t.ay = CoordW'(by + $urandom_range(span));
      t.bx = CoordW'(bx + $urandom_range(span));
      t.by_row = CoordW'(by + $urandom_range(span));
      t.cx = CoordW'(bx + $urandom_range(span));
      t.cy = CoordW'(by + $urandom_range(span));
      t.px = CoordW'(bx + $urandom_range(span));
      t.py = CoordW'(by + $urandom_range(span));
    end else begin
      t.mode = ModeTest;
    end
    return t;
  endfunction

  task automatic test_directed();
    // Extremes of coordinates and depths on a full-screen triangle.
    send_item(make_tri(0, 0, 1023, 0, 0, 1023, 32767, -32768, 0, 0, 0));
    send_item(make_tri(0, 0, 1023, 0, 0, 1023, 32767, -32768, 0, 1023, 0));
    send_item(make_tri(0, 0, 1023, 0, 0, 1023, 32767, -32768, 0, 0, 1023));
    send_item(make_tri(0, 0, 1023, 0, 0, 1023, 1000, 1000, 1000, 300, 300));
    // Outside, and the other winding.
    send_item(make_tri(0, 0, 1023, 0, 0, 1023, 5, 5, 5, 1023, 1023));
    send_item(make_tri(0, 0, 0, 1023, 1023, 0, -200, 300, 100, 100, 100));
    // Equal depth does not write, lower does not, higher does.
    send_item(make_tri(0, 0, 0, 1023, 1023, 0, -200, 300, 100, 100, 100));
    send_item(make_tri(0, 0, 0, 1023, 1023, 0, -300, -300, -300, 100, 100));
    send_item(make_tri(0, 0, 0, 1023, 1023, 0, 32767, 32767, 32767, 100, 100));
    // Minimum depth never writes into a cleared entry.
    send_item(make_tri(10, 10, 20, 10, 10, 20, -32768, -32768, -32768, 12, 12));
    // Degenerate: collinear and coincident vertices.
    send_item(make_tri(0, 0, 5, 5, 10, 10, 100, 100, 100, 5, 5));
    send_item(make_tri(7, 7, 7, 7, 7, 7, 100, 100, 100, 7, 7));
    // Edge and vertex pixels count as inside.
    send_item(make_tri(100, 100, 200, 100, 100, 200, 10, 20, 30, 150, 100));
    send_item(make_tri(100, 100, 200, 100, 100, 200, 10, 20, 30, 200, 100));
    send_item(make_tri(100, 100, 200, 100, 100, 200, 10, 20, 30, 150, 150));
    // Clear an entry then write it again; also clear at the corners.
    send_item(make_clear(100, 100));
    send_item(make_tri(0, 0, 0, 1023, 1023, 0, -300, -300, -300, 100, 100));
    send_item(make_clear(0, 0));
    send_item(make_clear(1023, 1023));
    send_item(make_tri(0, 0, 0, 1023, 1023, 0, 7, 7, 7, 0, 0));
    drain();
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_item(random_item());
    drain();
    recv_stall_pct = 0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(190, 0, 0);
    test_random(190, 53, 0);
    test_random(190, 0, 53);
    test_random(190, 30, 30);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("triangle_zbuffer_pixel_test_top verification clean");
    end else begin
      $display("triangle_zbuffer_pixel_test_top verification failed");
    end
    $finish;
  end
endmodule
